// File: rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared types and constants of the motion sequence player: commands,
// table entry layout and per-channel state layout.
// ----------------------------------------------------------------------------
package msp_pkg;

  // command codes
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_SET   = 2'd2;

  // table codes of a write
  localparam logic [1:0] TABLE_A = 2'd0;
  localparam logic [1:0] TABLE_B = 2'd1;
  localparam logic [1:0] TABLE_C = 2'd2;

  // selection code for an idle channel
  localparam logic [1:0] SEL_NONE = 2'd0;

  localparam int unsigned NUM_TABLES = 3;

  // step index covers the largest table size plus the one-past-end hold value
  localparam int unsigned STEP_W = 9;

  typedef struct packed {
    logic [15:0] time_val;
    logic [15:0] angle;
    logic        is_end;
  } entry_t;

  typedef struct packed {
    logic [1:0]        sel;
    logic              single;
    logic [STEP_W-1:0] step;
    logic [31:0]       count;
    logic [15:0]       angle;
  } chan_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);
  localparam int unsigned CHAN_W  = $bits(chan_t);

endpackage

// File: rtl/core/msp_ram.sv
// ----------------------------------------------------------------------------
// msp_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module msp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/msp_chan_upd.sv
// ----------------------------------------------------------------------------
// msp_chan_upd
// Per-tick update of one channel: idle clear, end-of-table hold, tick
// counting against the step length, step advance or wrap, and single-shot stop.
// ----------------------------------------------------------------------------
module msp_chan_upd #(
  parameter int unsigned STEPS = 128
) (
  input  msp_pkg::chan_t  chan_i,
  input  msp_pkg::entry_t entry_i,
  input  logic [15:0]     len_i,
  output msp_pkg::chan_t  chan_o,
  output logic            running_o,
  output logic            active_o
);
  import msp_pkg::*;

  logic [31:0] cnt_inc;
  logic        in_range;

  assign cnt_inc   = chan_i.count + 32'd1;
  assign in_range  = chan_i.step < STEP_W'(STEPS);
  assign running_o = chan_i.sel != SEL_NONE;
  assign active_o  = running_o && in_range;

  always_comb begin
    chan_o = chan_i;
    if (!running_o) begin
      chan_o.step = '0;
    end else if (in_range) begin
      chan_o.angle = entry_i.angle;
      if (cnt_inc >= {16'd0, len_i}) begin
        chan_o.count = '0;
        if (entry_i.is_end) begin
          chan_o.step = '0;
          if (chan_i.single) begin
            chan_o.sel = SEL_NONE;
          end
        end else begin
          chan_o.step = chan_i.step + STEP_W'(1);
        end
      end else begin
        chan_o.count = cnt_inc;
      end
    end
  end

endmodule

// File: rtl/core/motion_sequence_player_top.sv
// ----------------------------------------------------------------------------
// motion_sequence_player_top
// Timed angle sequence player: three entry tables in one RAM, per-channel
// playback state in a second RAM, served one channel at a time per tick.
// ----------------------------------------------------------------------------
// A table write leaves busy low, so writes can follow every cycle. A channel
// set raises busy for one cycle (write back of the channel state read in the
// accepting cycle), and the next transaction can come once busy is low
// again. A tick walks the channels in order and gives one result per
// channel, channel 0 first; an idle or held channel is served by the channel
// state read alone, a playing channel goes through channel state read,
// current entry read, previous entry read, and length and update, each read
// waiting on the registered read data of the two RAMs; busy stays high until
// the last channel of the tick is served. Each result is registered and
// shows in the cycle after its channel is served, so the last result of a
// tick appears in the first cycle with busy low. Results appear as
// single-cycle pulses on result_valid_o and are not held: the receiver must
// take every result in the cycle it is shown.
module motion_sequence_player_top #(
  parameter int unsigned CHANNELS = 2,
  parameter int unsigned STEPS    = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [1:0]  table_choice_i,
  input  logic [6:0]  entry_index_i,
  input  logic [15:0] entry_time_i,
  input  logic [15:0] entry_angle_i,
  input  logic        entry_is_end_i,
  input  logic        channel_in_i,
  input  logic [1:0]  sequence_sel_i,
  input  logic        single_shot_i,
  output logic        result_valid_o,
  output logic        channel_out_o,
  output logic        running_o,
  output logic [15:0] goal_angle_o,
  output logic [7:0]  step_now_o,
  output logic        last_result_o
);
  import msp_pkg::*;

  localparam int unsigned CHW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned SEQ_DEPTH = NUM_TABLES * STEPS;
  localparam int unsigned SAW       = $clog2(SEQ_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SET  = 3'd1;
  localparam logic [2:0] ST_CH   = 3'd2;
  localparam logic [2:0] ST_CUR  = 3'd3;
  localparam logic [2:0] ST_PREV = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;

  function automatic logic [SAW-1:0] tbl_base(input logic [1:0] tab);
    logic [SAW-1:0] b;
    unique case (tab)
      TABLE_A: b = '0;
      TABLE_B: b = SAW'(STEPS);
      default: b = SAW'(2 * STEPS);
    endcase
    return b;
  endfunction

  logic [2:0]     state_q, state_d;
  logic [CHW-1:0] ch_q, ch_d;
  logic [1:0]     set_sel_q;
  logic           set_single_q;
  chan_t          chst_q;
  entry_t         cur_q;
  logic [15:0]    len_q, len_d;
  logic [SAW-1:0] addr_q;
  logic [CHANNELS-1:0] valid_q;

  logic                seq_we, seq_re;
  logic [SAW-1:0]      seq_waddr, seq_raddr;
  logic [ENTRY_W-1:0]  seq_rdata;
  entry_t              seq_rd;

  logic                ch_we, ch_re;
  logic [CHW-1:0]      ch_raddr;
  chan_t               ch_wdata;
  logic [CHAN_W-1:0]   ch_rdata;
  chan_t               ch_rd;

  chan_t       upd_in, upd_out;
  logic        upd_running, upd_active;
  logic        emit, is_last;
  logic [15:0] prev_time, diff;

  logic        res_valid_q;
  logic        res_ch_q, res_run_q, res_last_q;
  logic [15:0] res_angle_q;
  logic [7:0]  res_step_q;

  assign busy    = state_q != ST_IDLE;
  assign seq_rd  = entry_t'(seq_rdata);
  assign ch_rd   = valid_q[ch_q] ? chan_t'(ch_rdata) : '0;
  assign is_last = ch_q == CHW'(CHANNELS - 1);
  assign upd_in  = (state_q == ST_CH) ? ch_rd : chst_q;

  assign seq_waddr = tbl_base(table_choice_i) + SAW'(entry_index_i);

  assign prev_time = (chst_q.step == '0) ? 16'd0 : seq_rd.time_val;
  assign diff      = cur_q.time_val - prev_time;

  msp_chan_upd #(
    .STEPS (STEPS)
  ) u_upd (
    .chan_i    (upd_in),
    .entry_i   (cur_q),
    .len_i     (len_q),
    .chan_o    (upd_out),
    .running_o (upd_running),
    .active_o  (upd_active)
  );

  // busy interlocks all channel RAM accesses, so read and write never hit
  // the same entry in flight
  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    len_d     = len_q;
    seq_we    = 1'b0;
    seq_re    = 1'b0;
    seq_raddr = addr_q;
    ch_we     = 1'b0;
    ch_re     = 1'b0;
    ch_raddr  = ch_q;
    ch_wdata  = upd_out;
    emit      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd_i)
            CMD_WRITE: begin
              seq_we = (32'(table_choice_i) < NUM_TABLES) && (32'(entry_index_i) < STEPS);
            end
            CMD_SET: begin
              if (32'(channel_in_i) < CHANNELS) begin
                ch_re    = 1'b1;
                ch_raddr = CHW'(channel_in_i);
                ch_d     = CHW'(channel_in_i);
                state_d  = ST_SET;
              end
            end
            CMD_TICK: begin
              ch_re    = 1'b1;
              ch_raddr = '0;
              ch_d     = '0;
              state_d  = ST_CH;
            end
            default: ;
          endcase
        end
      end
      ST_SET: begin
        ch_we           = 1'b1;
        ch_wdata        = ch_rd;
        ch_wdata.sel    = set_sel_q;
        ch_wdata.single = set_single_q;
        state_d         = ST_IDLE;
      end
      ST_CH: begin
        if (upd_active) begin
          seq_re    = 1'b1;
          seq_raddr = tbl_base(ch_rd.sel - 2'd1) + SAW'(ch_rd.step);
          state_d   = ST_CUR;
        end else begin
          emit  = 1'b1;
          ch_we = 1'b1;
        end
      end
      ST_CUR: begin
        seq_re    = chst_q.step != '0;
        seq_raddr = addr_q - SAW'(1);
        state_d   = ST_PREV;
      end
      ST_PREV: begin
        len_d   = 16'({diff, 3'b000} + {3'b000, diff, 1'b0});
        state_d = ST_UPD;
      end
      ST_UPD: begin
        emit  = 1'b1;
        ch_we = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    // move on to the next channel once a result goes out, or to idle after the last one
    if (emit) begin
      if (is_last) begin
        state_d = ST_IDLE;
      end else begin
        ch_d     = ch_q + CHW'(1);
        ch_re    = 1'b1;
        ch_raddr = ch_d;
        state_d  = ST_CH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      valid_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ch_q        <= ch_d;
      res_valid_q <= emit;
      if (ch_we) begin
        valid_q[ch_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    if (start && !busy) begin
      set_sel_q    <= sequence_sel_i;
      set_single_q <= single_shot_i;
    end
    if (state_q == ST_CH) begin
      chst_q <= ch_rd;
      addr_q <= seq_raddr;
    end
    if (state_q == ST_CUR) begin
      cur_q <= seq_rd;
    end
    if (emit) begin
      res_ch_q    <= ch_q[0];
      res_run_q   <= upd_running;
      res_angle_q <= upd_out.angle;
      res_step_q  <= upd_out.step[7:0];
      res_last_q  <= is_last;
    end
  end

  msp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SEQ_DEPTH)
  ) u_seq_ram (
    .clk_i   (clk_i),
    .we_i    (seq_we),
    .waddr_i (seq_waddr),
    .wdata_i ({entry_time_i, entry_angle_i, entry_is_end_i}),
    .re_i    (seq_re),
    .raddr_i (seq_raddr),
    .rdata_o (seq_rdata)
  );

  msp_ram #(
    .WIDTH (CHAN_W),
    .DEPTH (CHANNELS)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (ch_we),
    .waddr_i (ch_q),
    .wdata_i (ch_wdata),
    .re_i    (ch_re),
    .raddr_i (ch_raddr),
    .rdata_o (ch_rdata)
  );

  assign result_valid_o = res_valid_q;
  assign channel_out_o  = res_ch_q;
  assign running_o      = res_run_q;
  assign goal_angle_o   = res_angle_q;
  assign step_now_o     = res_step_q;
  assign last_result_o  = res_last_q;

endmodule

// File: rtl/core/msp_checker.sv
// ----------------------------------------------------------------------------
// msp_checker
// Port-level checks of the motion sequence player: result timing against
// busy and consistency of idle results.
// ----------------------------------------------------------------------------
module msp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       result_valid_o,
  input logic       running_o,
  input logic [7:0] step_now_o,
  input logic       last_result_o
);

  // no result can follow a transaction in the very next cycle
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> !result_valid_o)
    else $error("result right after an accepted transaction");

  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_result_o |-> busy)
    else $error("non-final result while not busy");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_result_o |-> !busy)
    else $error("still busy at the final result of a tick");

  // an idle channel always reports step zero
  a_idle_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !running_o |-> step_now_o == 8'd0)
    else $error("idle channel with nonzero step");

endmodule

bind motion_sequence_player_top msp_checker u_msp_checker (.*);

// File: test/motion_sequence_player_top_tb.sv
// ----------------------------------------------------------------------------
// motion_sequence_player_top_tb
// Drives table writes, channel selections and ticks into the sequence player.
// A short table of directed transactions comes first, then every entry of
// the three tables is loaded and a random mix of commands follows. Each
// result is compared with the expected values of its directed row or the
// output of a player model; the oldest expected result is taken first.
// ----------------------------------------------------------------------------
module motion_sequence_player_top_tb;
  import msp_pkg::*;

  localparam int unsigned CHANNELS = 2;
  localparam int unsigned STEPS    = 128;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [1:0] TABLE_NONE = 2'd3;
  localparam logic [1:0] SEL_A      = 2'd1;
  localparam logic [1:0] SEL_B      = 2'd2;
  localparam logic [1:0] SEL_C      = 2'd3;

  localparam int RANDOM_ITEMS   = 560;
  localparam int CALM_ITEMS     = 130;
  localparam int DRAIN_CYCLES   = 8 * CHANNELS;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [1:0]  table_choice;
    logic [6:0]  entry_index;
    logic [15:0] entry_time;
    logic [15:0] entry_angle;
    logic        entry_is_end;
    logic        channel_in;
    logic [1:0]  sequence_sel;
    logic        single_shot;
  } item_t;

  typedef struct packed {
    logic        chan;
    logic        running;
    logic [15:0] angle;
    logic [7:0]  step;
    logic        last;
  } result_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t r0;
    result_t r1;
  } dir_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   drv_item = '0;
  logic    drv_typed = 1'b0;
  result_t drv_exp0 = '0;
  result_t drv_exp1 = '0;

  logic        result_valid_o;
  logic        channel_out_o;
  logic        running_o;
  logic [15:0] goal_angle_o;
  logic [7:0]  step_now_o;
  logic        last_result_o;

  // player model state
  entry_t      seq_mem [NUM_TABLES*STEPS];
  logic [7:0]  step_q  [CHANNELS];
  logic [31:0] count_q [CHANNELS];
  logic [1:0]  sel_q   [CHANNELS];
  logic        single_q[CHANNELS];
  logic [15:0] angle_q [CHANNELS];
  result_t     tick_reports[CHANNELS];

  result_t  due_reports[$];
  dir_row_t directed_rows[$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       pauses_on = 1'b1;

  always #5 clk_i = ~clk_i;

  motion_sequence_player_top #(
    .CHANNELS(CHANNELS),
    .STEPS   (STEPS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (drv_item.cmd),
    .table_choice_i(drv_item.table_choice),
    .entry_index_i (drv_item.entry_index),
    .entry_time_i  (drv_item.entry_time),
    .entry_angle_i (drv_item.entry_angle),
    .entry_is_end_i(drv_item.entry_is_end),
    .channel_in_i  (drv_item.channel_in),
    .sequence_sel_i(drv_item.sequence_sel),
    .single_shot_i (drv_item.single_shot),
    .result_valid_o(result_valid_o),
    .channel_out_o (channel_out_o),
    .running_o     (running_o),
    .goal_angle_o  (goal_angle_o),
    .step_now_o    (step_now_o),
    .last_result_o (last_result_o)
  );

  // applies one command to the model, returns the number of channel reports
  function automatic int model_command(input item_t it);
    int unsigned base;
    logic [15:0] len;
    entry_t      cur;
    logic        was_on;
    if (it.cmd == CMD_WRITE) begin
      if (it.table_choice != TABLE_NONE)
        seq_mem[int'(it.table_choice)*STEPS + int'(it.entry_index)] =
          {it.entry_time, it.entry_angle, it.entry_is_end};
      return 0;
    end
    if (it.cmd == CMD_SET) begin
      sel_q[it.channel_in]    = it.sequence_sel;
      single_q[it.channel_in] = it.single_shot;
      return 0;
    end
    if (it.cmd != CMD_TICK) return 0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      was_on = (sel_q[ch] != SEL_NONE);
      if (!was_on) begin
        step_q[ch] = '0;
      end else if (step_q[ch] < STEPS) begin
        base = (int'(sel_q[ch]) - 1) * STEPS;
        cur  = seq_mem[base + step_q[ch]];
        len  = cur.time_val;
        if (step_q[ch] != 0) len = cur.time_val - seq_mem[base + step_q[ch] - 1].time_val;
        len = len * 16'd10;
        angle_q[ch] = cur.angle;
        count_q[ch] = count_q[ch] + 32'd1;
        if (count_q[ch] >= {16'd0, len}) begin
          count_q[ch] = '0;
          step_q[ch]  = step_q[ch] + 8'd1;
          if (cur.is_end) begin
            step_q[ch] = '0;
            if (single_q[ch]) sel_q[ch] = SEL_NONE;
          end
        end
      end
      tick_reports[ch] = {1'(ch), was_on, angle_q[ch], step_q[ch], 1'(ch == CHANNELS - 1)};
    end
    return CHANNELS;
  endfunction

  function automatic result_t res(logic ch, logic run, logic [15:0] ang, logic [7:0] stp,
                                  logic last);
    return {ch, run, ang, stp, last};
  endfunction

  function automatic item_t tick_item();
    item_t it;
    it     = '0;
    it.cmd = CMD_TICK;
    return it;
  endfunction

  function automatic item_t wr_item(logic [1:0] tab, logic [6:0] idx, logic [15:0] t,
                                    logic [15:0] ang, logic last);
    item_t it;
    it              = '0;
    it.cmd          = CMD_WRITE;
    it.table_choice = tab;
    it.entry_index  = idx;
    it.entry_time   = t;
    it.entry_angle  = ang;
    it.entry_is_end = last;
    return it;
  endfunction

  function automatic item_t set_item(logic ch, logic [1:0] sel, logic once);
    item_t it;
    it              = '0;
    it.cmd          = CMD_SET;
    it.channel_in   = ch;
    it.sequence_sel = sel;
    it.single_shot  = once;
    return it;
  endfunction

  function automatic item_t junk_item();
    item_t it;
    it.cmd          = 2'($urandom);
    it.table_choice = 2'($urandom);
    it.entry_index  = 7'($urandom);
    it.entry_time   = 16'($urandom);
    it.entry_angle  = 16'($urandom);
    it.entry_is_end = 1'($urandom);
    it.channel_in   = 1'($urandom);
    it.sequence_sel = 2'($urandom);
    it.single_shot  = 1'($urandom);
    return it;
  endfunction

  // cumulative times mostly repeat or creep up so steps stay short
  function automatic logic [15:0] pick_time(logic [15:0] prev, bit wild);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return prev;
    if (r < 90) return prev + 16'd1;
    if (r < 95 || !wild) return prev + 16'd2;
    return 16'($urandom);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s expected %0h got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic issue(input item_t it, input logic typed, input result_t e0,
                       input result_t e1);
    start     <= 1'b1;
    drv_item  <= it;
    drv_typed <= typed;
    drv_exp0  <= e0;
    drv_exp1  <= e1;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic maybe_pause();
    int n;
    if (pauses_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : check_reports
    result_t want;
    int      n;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (due_reports.size() == 0) begin
          $error("result with no transaction pending, channel %0d", channel_out_o);
          mismatches++;
        end else begin
          want = due_reports.pop_front();
          check_field("channel_out", int'(want.chan), int'(channel_out_o));
          check_field("running", int'(want.running), int'(running_o));
          check_field("goal_angle", int'(want.angle), int'(goal_angle_o));
          check_field("step_now", int'(want.step), int'(step_now_o));
          check_field("last_result", int'(want.last), int'(last_result_o));
        end
      end
      if (start && !busy) begin
        n = model_command(drv_item);
        for (int k = 0; k < n; k++)
          due_reports.push_back(drv_typed ? (k == 0 ? drv_exp0 : drv_exp1) : tick_reports[k]);
      end
    end
  end

  // counts cycles with no transaction either way and fails the run past the watchdog limit
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL motion_sequence_player_top");
        $finish;
      end
    end
  end

  initial begin
    item_t       it;
    dir_row_t    row;
    logic [15:0] prev;
    int          counted;
    int          pick;
    bit          ignored;
    bit          drained;

    for (int ch = 0; ch < CHANNELS; ch++) begin
      step_q[ch]   = '0;
      count_q[ch]  = '0;
      sel_q[ch]    = SEL_NONE;
      single_q[ch] = 1'b0;
      angle_q[ch]  = '0;
    end

    // tick after reset, single shot, ignored commands, extremes of time and index
    directed_rows.push_back({tick_item(), 1'b1, res(1'b0, 1'b0, 16'h0000, 8'd0, 1'b0),
                             res(1'b1, 1'b0, 16'h0000, 8'd0, 1'b1)});
    directed_rows.push_back({wr_item(TABLE_A, 7'd0, 16'h0000, 16'hFFFF, 1'b1), 1'b0,
                             54'd0});
    directed_rows.push_back({wr_item(TABLE_NONE, 7'd127, 16'hFFFF, 16'hFFFF, 1'b1), 1'b0,
                             54'd0});
    it     = junk_item();
    it.cmd = CMD_UNUSED;
    directed_rows.push_back({it, 1'b0, 54'd0});
    directed_rows.push_back({set_item(1'b0, SEL_A, 1'b1), 1'b0, 54'd0});
    directed_rows.push_back({tick_item(), 1'b1, res(1'b0, 1'b1, 16'hFFFF, 8'd0, 1'b0),
                             res(1'b1, 1'b0, 16'h0000, 8'd0, 1'b1)});
    directed_rows.push_back({tick_item(), 1'b1, res(1'b0, 1'b0, 16'hFFFF, 8'd0, 1'b0),
                             res(1'b1, 1'b0, 16'h0000, 8'd0, 1'b1)});
    directed_rows.push_back({wr_item(TABLE_B, 7'd0, 16'h0000, 16'h0001, 1'b0), 1'b0,
                             54'd0});
    directed_rows.push_back({wr_item(TABLE_B, 7'd1, 16'hFFFF, 16'h8000, 1'b1), 1'b0,
                             54'd0});
    directed_rows.push_back({set_item(1'b1, SEL_B, 1'b0), 1'b0, 54'd0});
    directed_rows.push_back({tick_item(), 1'b1, res(1'b0, 1'b0, 16'hFFFF, 8'd0, 1'b0),
                             res(1'b1, 1'b1, 16'h0001, 8'd1, 1'b1)});
    directed_rows.push_back({tick_item(), 1'b1, res(1'b0, 1'b0, 16'hFFFF, 8'd0, 1'b0),
                             res(1'b1, 1'b1, 16'h8000, 8'd1, 1'b1)});
    directed_rows.push_back({set_item(1'b1, SEL_NONE, 1'b1), 1'b0, 54'd0});
    directed_rows.push_back({tick_item(), 1'b1, res(1'b0, 1'b0, 16'hFFFF, 8'd0, 1'b0),
                             res(1'b1, 1'b0, 16'h8000, 8'd0, 1'b1)});
    directed_rows.push_back({wr_item(TABLE_C, 7'd127, 16'hFFFF, 16'hAAAA, 1'b0), 1'b0,
                             54'd0});
    directed_rows.push_back({wr_item(TABLE_C, 7'd0, 16'h0001, 16'h5555, 1'b0), 1'b0,
                             54'd0});
    directed_rows.push_back({set_item(1'b0, SEL_C, 1'b0), 1'b0, 54'd0});
    directed_rows.push_back({tick_item(), 1'b0, 54'd0});
    directed_rows.push_back({set_item(1'b1, SEL_B, 1'b1), 1'b0, 54'd0});
    directed_rows.push_back({tick_item(), 1'b0, 54'd0});
    directed_rows.push_back({tick_item(), 1'b0, 54'd0});
    directed_rows.push_back({set_item(1'b1, SEL_NONE, 1'b0), 1'b0, 54'd0});
    directed_rows.push_back({set_item(1'b0, SEL_NONE, 1'b0), 1'b0, 54'd0});
    directed_rows.push_back({tick_item(), 1'b0, 54'd0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      issue(row.it, row.typed, row.r0, row.r1);
      maybe_pause();
    end

    // load every entry before any random selection; table C runs end to end
    for (int tab = 0; tab < NUM_TABLES; tab++) begin
      prev = '0;
      for (int idx = 0; idx < STEPS; idx++) begin
        prev = (2'(tab) == TABLE_C) ? prev : pick_time(prev, 1'b1);
        issue(wr_item(2'(tab), 7'(idx), prev, 16'($urandom),
                      (2'(tab) != TABLE_C) && ($urandom_range(0, 7) == 0)),
              1'b0, '0, '0);
        maybe_pause();
      end
    end

    counted = 0;
    drained = 1'b0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 64 == 0) pauses_on = ($urandom_range(0, 2) != 0);
      if (counted >= RANDOM_ITEMS - CALM_ITEMS) pauses_on = 1'b0;
      if (!drained && counted >= RANDOM_ITEMS / 2) begin
        drained = 1'b1;
        start <= 1'b0;
        @(posedge clk_i);
        while (due_reports.size() != 0) @(posedge clk_i);
      end
      it      = junk_item();
      pick    = $urandom_range(0, 99);
      ignored = 1'b0;
      if (pick < 59) begin
        it.cmd = CMD_TICK;
      end else if (pick < 76) begin
        it.cmd          = CMD_WRITE;
        it.table_choice = 2'($urandom_range(0, 2));
        prev = (it.entry_index == 0) ? 16'd0 :
               seq_mem[int'(it.table_choice)*STEPS + int'(it.entry_index) - 1].time_val;
        it.entry_time   = pick_time(prev, it.table_choice != TABLE_C);
        it.entry_is_end = ($urandom_range(0, (it.table_choice == TABLE_C) ? 31 : 7) == 0);
      end else if (pick < 80) begin
        // fully random content, table choice of none included
        it.cmd  = CMD_WRITE;
        ignored = (it.table_choice == TABLE_NONE);
      end else if (pick < 92) begin
        it.cmd = CMD_SET;
      end else begin
        it.cmd  = CMD_UNUSED;
        ignored = 1'b1;
      end
      issue(it, 1'b0, '0, '0);
      if (!ignored) counted++;
      maybe_pause();
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (due_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS motion_sequence_player_top");
    end else begin
      $display("FAIL motion_sequence_player_top");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/msp_pkg.sv
rtl/core/msp_ram.sv
rtl/core/msp_chan_upd.sv
rtl/core/motion_sequence_player_top.sv
rtl/core/msp_checker.sv
test/motion_sequence_player_top_tb.sv
